/* hdl/dpbs_pkg.sv */
// ----------------------------------------------------------------------------
// dpbs_pkg
// shared types, codes and step tables for the debug port bit sequencer
// ----------------------------------------------------------------------------
package dpbs_pkg;

    localparam int TIMER_BITS = 20;
    localparam int TIMER_LW   = (TIMER_BITS > 20) ? TIMER_BITS : 20;

    localparam int HALF_W   = 16;
    localparam int RWAIT_W  = 20;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RWAIT = 1'd1;

    localparam logic [HALF_W-1:0]  HALF_RESET  = 16'd50;
    localparam logic [RWAIT_W-1:0] RWAIT_RESET = 20'd1000;

    localparam logic [2:0] CMD_IDLE  = 3'd0;
    localparam logic [2:0] CMD_SEND  = 3'd1;
    localparam logic [2:0] CMD_RECV  = 3'd2;
    localparam logic [2:0] CMD_DEBUG = 3'd3;
    localparam logic [2:0] CMD_RESET = 3'd4;

    // pin latch bits: [2] reset_n, [1] data, [0] clock
    localparam logic [2:0] PINS_ALL_HIGH = 3'b111;

    localparam logic [3:0] STEP_WAIT = 4'd8;

    localparam logic [3:0] DEBUG_STEPS [8] = '{4'd7, 4'd2, STEP_WAIT, 4'd3,
                                               4'd2, 4'd3, 4'd6, STEP_WAIT};
    localparam logic [3:0] RESET_STEPS [8] = '{4'd7, 4'd3, STEP_WAIT, 4'd3,
                                               4'd3, 4'd3, 4'd7, STEP_WAIT};

    typedef logic [TIMER_BITS-1:0] t_timer;

    typedef struct packed {
        logic [2:0] cmd;
        logic [4:0] idx;
        logic [7:0] shift;
        logic       rel;
        logic [2:0] pin;
    } t_step_req;

    typedef struct packed {
        logic [2:0] pin;
        t_timer     count;
    } t_step_res;

    // zero counts as one tick, saturate to the timer width
    function automatic t_timer load_count(input logic [RWAIT_W-1:0] v);
        logic [TIMER_LW-1:0] x;
        logic [TIMER_LW-1:0] cap;
        cap = TIMER_LW'({TIMER_BITS{1'b1}});
        x   = TIMER_LW'(v);
        if (x == '0) begin
            x = TIMER_LW'(1);
        end
        if (x > cap) begin
            x = cap;
        end
        return x[TIMER_BITS-1:0];
    endfunction

endpackage

/* hdl/dpbs_in_if.sv */
// ----------------------------------------------------------------------------
// dpbs_in_if
// command / tick channel into the sequencer
// ----------------------------------------------------------------------------
interface dpbs_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       release_first;
    logic       data_sample;

    modport source (output valid, func, tx_byte, release_first, data_sample,
                    input ready);
    modport sink   (input valid, func, tx_byte, release_first, data_sample,
                    output ready);
endinterface

/* hdl/dpbs_out_if.sv */
// ----------------------------------------------------------------------------
// dpbs_out_if
// result channel out of the sequencer
// ----------------------------------------------------------------------------
interface dpbs_out_if;
    logic       valid;
    logic       ready;
    logic       clock_level;
    logic       data_level;
    logic       reset_level;
    logic       busy_res;
    logic       accepted;
    logic       done_res;
    logic       rx_valid;
    logic [7:0] rx_byte;

    modport source (output valid, clock_level, data_level, reset_level, busy_res,
                    accepted, done_res, rx_valid, rx_byte,
                    input ready);
    modport sink   (input valid, clock_level, data_level, reset_level, busy_res,
                    accepted, done_res, rx_valid, rx_byte,
                    output ready);
endinterface

/* hdl/dpbs_step.sv */
// ----------------------------------------------------------------------------
// dpbs_step
// pin levels and hold count for the step a command enters
// ----------------------------------------------------------------------------
module dpbs_step
    import dpbs_pkg::*;
(
    input  t_step_req           i_req,
    input  logic [HALF_W-1:0]   i_half,
    input  logic [RWAIT_W-1:0]  i_rwait,
    output t_step_res           o_step
);

    logic       w_bit;
    logic       w_dat;
    logic [3:0] w_entry;
    t_timer     w_half_cnt;

    assign w_half_cnt = load_count(RWAIT_W'(i_half));
    assign w_bit      = i_req.shift[3'd7 - i_req.idx[3:1]];
    assign w_entry    = (i_req.cmd == CMD_DEBUG) ? DEBUG_STEPS[i_req.idx[2:0]]
                                                 : RESET_STEPS[i_req.idx[2:0]];

    always_comb begin
        w_dat        = i_req.pin[1];
        o_step.pin   = i_req.pin;
        o_step.count = w_half_cnt;
        case (i_req.cmd)
            CMD_SEND: begin
                o_step.pin = {1'b1, w_bit, ~i_req.idx[0]};
            end
            CMD_RECV: begin
                if (i_req.idx == 5'd0 && i_req.rel) begin
                    w_dat = 1'b1;
                end
                o_step.pin = {1'b1, w_dat, ~i_req.idx[0]};
            end
            default: begin
                if (w_entry == STEP_WAIT) begin
                    o_step.count = load_count(i_rwait);
                end else begin
                    o_step.pin = w_entry[2:0];
                end
            end
        endcase
    end

endmodule

/* hdl/debug_port_bit_sequencer_core.sv */
// ----------------------------------------------------------------------------
// debug_port_bit_sequencer_core
// two-wire debug port master: steps clock, data and reset_n pin latches
// result: registered, valid in the cycle after its beat is accepted
// throughput: one beat per cycle while results are taken; a new beat is taken as the
// pending result is taken, and the input stalls only while the result register is full and not taken
// reset: synchronous active low, pins high, idle, state and config registers to defaults
// ----------------------------------------------------------------------------
module debug_port_bit_sequencer_core
    import dpbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dpbs_in_if.sink              i_cmd,
    dpbs_out_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [HALF_W-1:0]  r_half;
    logic [RWAIT_W-1:0] r_rwait;

    logic [2:0] r_pin,   n_pin;
    logic [2:0] r_cmd,   n_cmd;
    logic [4:0] r_idx,   n_idx;
    t_timer     r_wait,  n_wait;
    logic [7:0] r_shift, n_shift;
    logic       r_rel,   n_rel;

    logic       r_ovalid;
    logic       r_acc,  n_acc;
    logic       r_done, n_done;
    logic       r_rxv,  n_rxv;
    logic [7:0] r_rxb,  n_rxb;

    logic       w_take;
    logic [4:0] w_idx_inc;
    logic [7:0] w_shift_tk;
    logic [4:0] w_len;
    t_step_req  w_req;
    t_step_res  w_step;

    assign i_cmd.ready = !r_ovalid || o_res.ready;
    assign w_take      = i_cmd.valid && i_cmd.ready;

    assign w_idx_inc  = 5'(r_idx + 5'd1);
    assign w_len      = (r_cmd == CMD_SEND || r_cmd == CMD_RECV) ? 5'd16 : 5'd8;
    assign w_shift_tk = (r_cmd == CMD_RECV && !r_idx[0])
                      ? {r_shift[6:0], i_cmd.data_sample} : r_shift;

    always_comb begin
        if (i_cmd.func == CMD_IDLE) begin
            w_req = '{cmd: r_cmd, idx: w_idx_inc, shift: w_shift_tk,
                      rel: r_rel, pin: r_pin};
        end else begin
            w_req = '{cmd: i_cmd.func, idx: 5'd0,
                      shift: (i_cmd.func == CMD_SEND) ? i_cmd.tx_byte : 8'd0,
                      rel: (i_cmd.func == CMD_RECV) ? i_cmd.release_first : 1'b0,
                      pin: r_pin};
        end
    end

    dpbs_step u_step (
        .i_req   (w_req),
        .i_half  (r_half),
        .i_rwait (r_rwait),
        .o_step  (w_step)
    );

    always_comb begin
        n_pin   = r_pin;
        n_cmd   = r_cmd;
        n_idx   = r_idx;
        n_wait  = r_wait;
        n_shift = r_shift;
        n_rel   = r_rel;
        n_acc   = 1'b0;
        n_done  = 1'b0;
        n_rxv   = 1'b0;
        n_rxb   = 8'd0;
        if (i_cmd.func == CMD_IDLE) begin
            if (r_cmd != CMD_IDLE) begin
                if (r_wait > t_timer'(1)) begin
                    n_wait = r_wait - t_timer'(1);
                end else begin
                    n_shift = w_shift_tk;
                    if (w_idx_inc >= w_len) begin
                        n_done = 1'b1;
                        if (r_cmd == CMD_RECV) begin
                            n_rxv = 1'b1;
                            n_rxb = w_shift_tk;
                        end
                        n_cmd  = CMD_IDLE;
                        n_idx  = 5'd0;
                        n_wait = '0;
                    end else begin
                        n_idx  = w_idx_inc;
                        n_pin  = w_step.pin;
                        n_wait = w_step.count;
                    end
                end
            end
        end else if (i_cmd.func <= CMD_RESET && r_cmd == CMD_IDLE) begin
            n_acc   = 1'b1;
            n_cmd   = i_cmd.func;
            n_idx   = 5'd0;
            n_rel   = w_req.rel;
            n_shift = w_req.shift;
            n_pin   = w_step.pin;
            n_wait  = w_step.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= HALF_RESET;
            r_rwait <= RWAIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HALF:  r_half  <= i_cfg_data[HALF_W-1:0];
                CFG_RWAIT: r_rwait <= i_cfg_data[RWAIT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin    <= PINS_ALL_HIGH;
            r_cmd    <= CMD_IDLE;
            r_idx    <= 5'd0;
            r_wait   <= '0;
            r_shift  <= 8'd0;
            r_rel    <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (w_take) begin
            r_pin    <= n_pin;
            r_cmd    <= n_cmd;
            r_idx    <= n_idx;
            r_wait   <= n_wait;
            r_shift  <= n_shift;
            r_rel    <= n_rel;
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_acc  <= n_acc;
            r_done <= n_done;
            r_rxv  <= n_rxv;
            r_rxb  <= n_rxb;
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.clock_level = r_pin[0];
    assign o_res.data_level  = r_pin[1];
    assign o_res.reset_level = r_pin[2];
    assign o_res.busy_res    = (r_cmd != CMD_IDLE);
    assign o_res.accepted    = r_acc;
    assign o_res.done_res    = r_done;
    assign o_res.rx_valid    = r_rxv;
    assign o_res.rx_byte     = r_rxb;

endmodule

/* hdl/dpbs_checker.sv */
// ----------------------------------------------------------------------------
// dpbs_checker
// port-level checks on the sequencer core, bound to the core module
// ----------------------------------------------------------------------------
module dpbs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_busy,
    input logic       i_acc,
    input logic       i_done,
    input logic       i_rxv,
    input logic [7:0] i_rxb
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_rxb)
            && $stable(i_done) && $stable(i_busy))
        else $error("stalled result beat changed");

    // input is held off only by a full, untaken result register
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without a pending result");

    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_acc |-> i_busy && !i_done)
        else $error("accepted command not busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done |-> !i_busy)
        else $error("done while still busy");

    a_rx_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !(i_rxv && i_done) |-> !i_rxv && i_rxb == 8'd0
            || i_done && !i_rxv && i_rxb == 8'd0)
        else $error("received byte outside a receive completion");

endmodule

bind debug_port_bit_sequencer_core dpbs_checker u_dpbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_busy      (o_res.busy_res),
    .i_acc       (o_res.accepted),
    .i_done      (o_res.done_res),
    .i_rxv       (o_res.rx_valid),
    .i_rxb       (o_res.rx_byte)
);
